### rtl/tcon_pkg.sv
package tcon_pkg;

	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int TAB_STOP      = 8;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int OFF_W  = 11;
	localparam int CELL_W = 16;
	localparam int TAB_W  = $clog2(TAB_STOP + 1);

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [3:0] FG_RESET = 4'hF;
	localparam logic [3:0] BG_RESET = 4'h0;
	localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, CH_SPACE};

	// configuration register indexes
	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_SET   = 2'd3
	} action_t;

	typedef struct packed {
		action_t          action;
		logic [7:0]       char_code;
		logic [ROW_W-1:0] cell_row;
		logic [COL_W-1:0] cell_col;
	} in_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [OFF_W-1:0]  cursor_offset;
		logic [CELL_W-1:0] read_cell;
	} out_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

### rtl/tcon_ram.sv
module tcon_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/tcon_ctrl.sv
module tcon_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  tcon_pkg::in_t             cmd,
	input  logic [7:0]                attr,
	input  logic [tcon_pkg::CELL_W-1:0] rdata,
	output tcon_pkg::mem_req_t        mem,
	output logic                      busy,
	output logic                      done,
	output tcon_pkg::out_t            result
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_FILL,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK
	} state_t;

	localparam logic [tcon_pkg::ADDR_W-1:0] LAST_ADDR =
		tcon_pkg::ADDR_W'(tcon_pkg::CELL_COUNT - 1);
	localparam logic [tcon_pkg::ADDR_W-1:0] ROW_STEP =
		tcon_pkg::ADDR_W'(tcon_pkg::SCREEN_WIDTH);
	localparam logic [tcon_pkg::ADDR_W-1:0] LAST_ROW_ADDR =
		tcon_pkg::ADDR_W'(tcon_pkg::SCREEN_WIDTH * (tcon_pkg::SCREEN_HEIGHT - 1));
	localparam logic [tcon_pkg::COL_W-1:0] LAST_COL =
		tcon_pkg::COL_W'(tcon_pkg::SCREEN_WIDTH - 1);
	localparam logic [tcon_pkg::ROW_W-1:0] LAST_ROW =
		tcon_pkg::ROW_W'(tcon_pkg::SCREEN_HEIGHT - 1);

	state_t                        state_q;
	logic [tcon_pkg::COL_W-1:0]    col_q;
	logic [tcon_pkg::ROW_W-1:0]    row_q;
	logic [tcon_pkg::ADDR_W-1:0]   cnt_q;
	logic [tcon_pkg::TAB_W-1:0]    tab_left_q;
	logic [7:0]                    ch_q;
	logic [tcon_pkg::CELL_W-1:0]   read_q;
	logic                          done_q;
	logic                          copy_s1;
	logic [tcon_pkg::ADDR_W-1:0]   copy_addr_s1;

	logic                          accept;
	logic [tcon_pkg::COL_W-1:0]    col_cl;
	logic [tcon_pkg::ROW_W-1:0]    row_cl;
	logic [tcon_pkg::ADDR_W-1:0]   cur_addr;
	logic [tcon_pkg::ADDR_W-1:0]   cmd_addr;
	logic [tcon_pkg::CELL_W-1:0]   blank;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign blank  = {attr, tcon_pkg::CH_SPACE};

	assign col_cl = (cmd.cell_col >= tcon_pkg::COL_W'(tcon_pkg::SCREEN_WIDTH)) ?
		LAST_COL : cmd.cell_col;
	assign row_cl = (cmd.cell_row >= tcon_pkg::ROW_W'(tcon_pkg::SCREEN_HEIGHT)) ?
		LAST_ROW : cmd.cell_row;

	assign cur_addr = tcon_pkg::ADDR_W'(row_q) * ROW_STEP + tcon_pkg::ADDR_W'(col_q);
	assign cmd_addr = tcon_pkg::ADDR_W'(row_cl) * ROW_STEP + tcon_pkg::ADDR_W'(col_cl);

	always_comb begin
		mem = '0;
		unique case (state_q)
			ST_INIT: begin
				mem.we    = 1'b1;
				mem.waddr = cnt_q;
				mem.wdata = tcon_pkg::RESET_BLANK;
			end
			ST_FILL, ST_BLANK: begin
				mem.we    = 1'b1;
				mem.waddr = cnt_q;
				mem.wdata = blank;
			end
			ST_PUT: begin
				mem.we    = 1'b1;
				mem.waddr = cur_addr;
				mem.wdata = {attr, ch_q};
			end
			ST_COPY: begin
				mem.re    = 1'b1;
				mem.raddr = cnt_q;
			end
			ST_IDLE: begin
				if (accept && cmd.action == tcon_pkg::ACT_PUT &&
				    cmd.char_code == tcon_pkg::CH_BS && col_q != '0) begin
					mem.we    = 1'b1;
					mem.waddr = cur_addr - tcon_pkg::ADDR_W'(1);
					mem.wdata = blank;
				end
				if (accept && cmd.action == tcon_pkg::ACT_READ) begin
					mem.re    = 1'b1;
					mem.raddr = cmd_addr;
				end
			end
			ST_READ, ST_DRAIN: begin
			end
			default: begin
			end
		endcase
		// copied cell lands one row up, in the cycle after its read
		if (copy_s1) begin
			mem.we    = 1'b1;
			mem.waddr = copy_addr_s1;
			mem.wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			col_q        <= '0;
			row_q        <= '0;
			cnt_q        <= '0;
			tab_left_q   <= '0;
			ch_q         <= '0;
			read_q       <= '0;
			done_q       <= 1'b0;
			copy_s1      <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			done_q       <= 1'b0;
			copy_s1      <= (state_q == ST_COPY);
			copy_addr_s1 <= cnt_q - ROW_STEP;
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + tcon_pkg::ADDR_W'(1);
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + tcon_pkg::ADDR_W'(1);
					if (cnt_q == LAST_ADDR) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						read_q <= '0;
						unique case (cmd.action)
							tcon_pkg::ACT_PUT: begin
								priority if (cmd.char_code == tcon_pkg::CH_BS) begin
									if (col_q != '0) begin
										col_q <= col_q - tcon_pkg::COL_W'(1);
									end
									done_q <= 1'b1;
								end else if (cmd.char_code == tcon_pkg::CH_TAB) begin
									tab_left_q <= tcon_pkg::TAB_W'(tcon_pkg::TAB_STOP) -
										tcon_pkg::TAB_W'(col_q % tcon_pkg::TAB_STOP);
									ch_q    <= tcon_pkg::CH_SPACE;
									state_q <= ST_PUT;
								end else if (cmd.char_code == tcon_pkg::CH_NL) begin
									col_q <= '0;
									if (row_q == LAST_ROW) begin
										tab_left_q <= '0;
										cnt_q      <= ROW_STEP;
										state_q    <= ST_COPY;
									end else begin
										row_q  <= row_q + tcon_pkg::ROW_W'(1);
										done_q <= 1'b1;
									end
								end else begin
									tab_left_q <= tcon_pkg::TAB_W'(1);
									ch_q       <= cmd.char_code;
									state_q    <= ST_PUT;
								end
							end
							tcon_pkg::ACT_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							tcon_pkg::ACT_READ: begin
								state_q <= ST_READ;
							end
							tcon_pkg::ACT_SET: begin
								col_q  <= col_cl;
								row_q  <= row_cl;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					read_q  <= rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_PUT: begin
					tab_left_q <= tab_left_q - tcon_pkg::TAB_W'(1);
					if (col_q == LAST_COL) begin
						col_q <= '0;
						if (row_q == LAST_ROW) begin
							cnt_q   <= ROW_STEP;
							state_q <= ST_COPY;
						end else begin
							row_q <= row_q + tcon_pkg::ROW_W'(1);
							if (tab_left_q == tcon_pkg::TAB_W'(1)) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
					end else begin
						col_q <= col_q + tcon_pkg::COL_W'(1);
						if (tab_left_q == tcon_pkg::TAB_W'(1)) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + tcon_pkg::ADDR_W'(1);
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q   <= LAST_ROW_ADDR;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + tcon_pkg::ADDR_W'(1);
					if (cnt_q == LAST_ADDR) begin
						if (tab_left_q != '0) begin
							state_q <= ST_PUT;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done                 = done_q;
	assign result.cursor_col    = col_q;
	assign result.cursor_row    = row_q;
	assign result.cursor_offset = tcon_pkg::OFF_W'(cur_addr);
	assign result.read_cell     = read_q;

endmodule

### rtl/text_console_put_char.sv
// Text console: one item per start pulse, each result on done for one cycle.
// Set cursor, backspace and an on-screen newline finish straight from idle; a read
// goes via ST_READ, a printable and each space of a tab via ST_PUT. A scroll adds
// ST_COPY, ST_DRAIN and ST_BLANK, and a clear runs ST_FILL: one store cell per cycle.
// A new item is taken once the last is done; until then busy holds it off.
// Reset: async, active low; a clearing pass over every cell holds busy; no stall.
module text_console_put_char (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tcon_pkg::in_t        cmd,
	output logic                 busy,
	output logic                 done,
	output tcon_pkg::out_t       result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [3:0]               fg_q;
	logic [3:0]               bg_q;
	logic                     reg_sel;
	tcon_pkg::mem_req_t       mem;
	logic [tcon_pkg::CELL_W-1:0] rdata;

	// Register index sits in bit 2 of the byte address
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcon_pkg::FG_RESET;
			bg_q <= tcon_pkg::BG_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				tcon_pkg::REG_FG: fg_q <= pwdata[3:0];
				tcon_pkg::REG_BG: bg_q <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tcon_pkg::REG_FG: prdata = {28'd0, fg_q};
			tcon_pkg::REG_BG: prdata = {28'd0, bg_q};
		endcase
	end

	// Sequencer: cursor, dispatch, fill, scroll copy and last-row blanking
	tcon_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.attr   ({bg_q, fg_q}),
		.rdata  (rdata),
		.mem    (mem),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Screen store: one write and one registered read per cycle
	tcon_ram #(
		.WIDTH (tcon_pkg::CELL_W),
		.DEPTH (tcon_pkg::CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

`ifndef SYNTH
	// An accepted item either finishes at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither busy nor done");

	// Cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.cursor_col < tcon_pkg::COL_W'(tcon_pkg::SCREEN_WIDTH) &&
		          result.cursor_row < tcon_pkg::ROW_W'(tcon_pkg::SCREEN_HEIGHT)))
		else $error("cursor off screen");

	// No result while the sequencer is still working
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result during busy");
`endif

endmodule

### tb/text_console_put_char_tb.sv
module text_console_put_char_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcon_pkg::*;

	localparam int ITEMS_PER_PHASE = 265;
	localparam int N_PHASES        = 6;
	// A scroll or a clear walks the whole store; allow many times that long
	// with nothing accepted or done before calling it a hang.
	localparam int IDLE_LIMIT      = 20000;
	localparam int TAIL_CYCLES     = 40;
	localparam int MAX_REPORTS     = 10;

	// Mirror of the console: screen store, cursor and colours, plus the
	// cursor reports still owed by the block, oldest first.
	class console_mirror;
		logic [CELL_W-1:0] screen [CELL_COUNT];
		int unsigned       col;
		int unsigned       row;
		logic [3:0]        fg;
		logic [3:0]        bg;
		out_t              cursor_q[$];
		int                errors;

		function new();
			fg     = FG_RESET;
			bg     = BG_RESET;
			errors = 0;
			wipe();
		endfunction

		function logic [CELL_W-1:0] glyph(logic [7:0] ch);
			return {bg, fg, ch};
		endfunction

		function void wipe();
			for (int i = 0; i < CELL_COUNT; i++)
				screen[i] = glyph(CH_SPACE);
			col = 0;
			row = 0;
		endfunction

		function void scroll_up();
			if (row < SCREEN_HEIGHT)
				return;
			for (int i = SCREEN_WIDTH; i < CELL_COUNT; i++)
				screen[i - SCREEN_WIDTH] = screen[i];
			for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
				screen[i] = glyph(CH_SPACE);
			row = SCREEN_HEIGHT - 1;
		endfunction

		function void type_char(logic [7:0] ch);
			screen[row * SCREEN_WIDTH + col] = glyph(ch);
			col++;
			if (col >= SCREEN_WIDTH) begin
				col = 0;
				row++;
			end
			scroll_up();
		endfunction

		function void put_char(logic [7:0] ch);
			int unsigned pad;
			if (ch == CH_BS) begin
				// backspace at column zero leaves everything alone
				if (col > 0) begin
					col--;
					screen[row * SCREEN_WIDTH + col] = glyph(CH_SPACE);
				end
			end else if (ch == CH_TAB) begin
				pad = TAB_STOP - (col % TAB_STOP);
				repeat (pad) type_char(CH_SPACE);
			end else if (ch == CH_NL) begin
				col = 0;
				row++;
				scroll_up();
			end else begin
				type_char(ch);
			end
		endfunction

		function int unsigned clamp_to(int unsigned v, int unsigned lim);
			return (v >= lim) ? lim - 1 : v;
		endfunction

		function void set_colour(logic idx, logic [3:0] v);
			if (idx == REG_BG)
				bg = v;
			else
				fg = v;
		endfunction

		function int pending();
			return cursor_q.size();
		endfunction

		// Apply one accepted item and queue the report it must produce.
		function void note_cmd(in_t c);
			out_t        want;
			int unsigned r;
			int unsigned k;
			want.read_cell = '0;
			case (c.action)
				ACT_PUT:   put_char(c.char_code);
				ACT_CLEAR: wipe();
				ACT_READ: begin
					r = clamp_to(32'(c.cell_row), SCREEN_HEIGHT);
					k = clamp_to(32'(c.cell_col), SCREEN_WIDTH);
					want.read_cell = screen[r * SCREEN_WIDTH + k];
				end
				default: begin
					col = clamp_to(32'(c.cell_col), SCREEN_WIDTH);
					row = clamp_to(32'(c.cell_row), SCREEN_HEIGHT);
				end
			endcase
			want.cursor_col    = COL_W'(col);
			want.cursor_row    = ROW_W'(row);
			want.cursor_offset = OFF_W'(row * SCREEN_WIDTH + col);
			cursor_q.push_back(want);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (cursor_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%t: result with no item outstanding: %p", $realtime, got);
				return;
			end
			want = cursor_q.pop_front();
			if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
			    got.cursor_offset !== want.cursor_offset ||
			    got.read_cell !== want.read_cell) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%t: mismatch col %0d/%0d row %0d/%0d offset %0d/%0d cell %h/%h",
						$realtime, want.cursor_col, got.cursor_col,
						want.cursor_row, got.cursor_row,
						want.cursor_offset, got.cursor_offset,
						want.read_cell, got.read_cell);
			end
		endfunction
	endclass

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	in_t         cmd     = '0;
	logic        busy;
	logic        done;
	out_t        result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	console_mirror mirror;
	int unsigned   idle_cycles = 0;
	int            n_sent      = 0;
	int            burst_left  = 0;

	text_console_put_char u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sample at the rising edge. A result here belongs to an earlier item, so
	// check it before noting any item taken on this same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_result(result);
			if (start && !busy)
				mirror.note_cmd(cmd);
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Give up if nothing moves for too long.
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("** text_console_put_char: FAILED **");
		$finish;
	end

	// Pick the next burst: mostly short, now and then a long run with no gaps.
	task automatic next_burst();
		if ($urandom_range(0, 9) == 0)
			burst_left = $urandom_range(60, 160);
		else
			burst_left = $urandom_range(1, 24);
	endtask

	// Offer one item and hold it until taken; start stays high into the next
	// item unless the burst ends here, then drop it for a random gap.
	task automatic send(in_t c);
		int gap;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
		n_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			next_burst();
		end
	endtask

	// Hold off until every report owed has come and the block is idle.
	task automatic drain();
		start <= 1'b0;
		while (mirror.pending() != 0 || busy) @(negedge clk);
	endtask

	// One APB write: setup then access; the bus is left selected so that a
	// second write may follow straight on.
	task automatic write_reg(logic idx, logic [3:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {28'($urandom()), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mirror.set_colour(idx, v);
		@(negedge clk);
	endtask

	task automatic set_colours(logic [3:0] f, logic [3:0] b);
		write_reg(REG_FG, f);
		write_reg(REG_BG, b);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic in_t pack_item(action_t a, logic [7:0] ch,
	                                  logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		in_t it;
		it.action    = a;
		it.char_code = ch;
		it.cell_row  = r;
		it.cell_col  = c;
		return it;
	endfunction

	function automatic in_t put_item(logic [7:0] ch);
		return pack_item(ACT_PUT, ch, '0, '0);
	endfunction

	function automatic in_t read_item(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		return pack_item(ACT_READ, 8'($urandom()), r, c);
	endfunction

	function automatic in_t set_item(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		return pack_item(ACT_SET, 8'($urandom()), r, c);
	endfunction

	// Mostly on screen, with a share past the edge to exercise clamping.
	function automatic logic [ROW_W-1:0] pick_row();
		if ($urandom_range(0, 4) == 0)
			return ROW_W'($urandom_range(SCREEN_HEIGHT, 31));
		return ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
	endfunction

	function automatic logic [COL_W-1:0] pick_col();
		if ($urandom_range(0, 5) == 0)
			return COL_W'($urandom_range(SCREEN_WIDTH, 127));
		return COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
	endfunction

	function automatic logic [7:0] pick_put_char();
		case ($urandom_range(0, 19))
			0, 1:    return CH_TAB;
			2, 3:    return CH_NL;
			4, 5, 6: return CH_BS;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic directed();
		send(read_item(5'd0, 7'd0));       // untouched store reads blank
		send(put_item(CH_BS));             // backspace at column zero
		send(put_item(8'h41));
		send(put_item(8'h00));
		send(put_item(8'hFF));
		send(put_item(CH_BS));             // blank the cell just written
		send(put_item(CH_TAB));            // short pad to the next stop
		send(put_item(CH_TAB));            // at a stop: a full pad
		send(put_item(CH_NL));
		send(read_item(5'd0, 7'd0));
		send(read_item(5'd0, 7'd2));
		send(set_item(5'd31, 7'd127));     // clamps to the last cell
		send(put_item(8'h5A));             // wrap off the last cell and scroll
		send(read_item(5'd23, 7'd79));
		send(read_item(5'd24, 7'd0));
		send(set_item(5'd24, 7'd76));
		send(put_item(CH_TAB));            // pad reaches the row end and scrolls
		send(set_item(5'd25, 7'd5));
		send(put_item(CH_NL));             // newline on the last row scrolls
		send(read_item(5'd31, 7'd127));
		send(pack_item(ACT_CLEAR, 8'hFF, 5'd31, 7'd127));
		send(read_item(5'd12, 7'd40));
		send(set_item(5'd24, 7'd80));
		send(put_item(CH_BS));
	endtask

	// Random traffic: mostly a cursor placement followed by a run of puts
	// with reads mixed in; the rest is read-back, noise, rare clears and
	// the odd full drain.
	task automatic run_phase(int n_items);
		int      goal;
		int      sel;
		int      run;
		action_t a;
		goal = n_sent + n_items;
		while (n_sent < goal) begin
			sel = $urandom_range(0, 99);
			if (sel < 68) begin
				send(set_item(pick_row(), pick_col()));
				run = $urandom_range(1, 12);
				repeat (run) begin
					if ($urandom_range(0, 6) == 0)
						send(read_item(pick_row(), pick_col()));
					else
						send(pack_item(ACT_PUT, pick_put_char(),
							ROW_W'($urandom()), COL_W'($urandom())));
				end
			end else if (sel < 80) begin
				run = $urandom_range(1, 6);
				repeat (run) send(read_item(pick_row(), pick_col()));
			end else if (sel < 97) begin
				a = action_t'($urandom_range(0, 3));
				if (a == ACT_CLEAR)
					a = ACT_READ;
				send(pack_item(a, 8'($urandom()), ROW_W'($urandom()), COL_W'($urandom())));
			end else if (sel < 98) begin
				send(pack_item(ACT_CLEAR, 8'($urandom()), ROW_W'($urandom()),
					COL_W'($urandom())));
			end else begin
				drain();
			end
		end
	endtask

	initial begin
		mirror = new();
		next_burst();

		// hold reset, then wait out the clearing pass
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);

		// directed checks run at the reset colours
		directed();

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			case (p)
				0:       set_colours(4'h0, 4'h0);
				1:       set_colours(4'hF, 4'hF);
				2:       set_colours(4'h0, 4'hF);
				3:       set_colours(4'hF, 4'h0);
				default: set_colours(4'($urandom()), 4'($urandom()));
			endcase
			run_phase(ITEMS_PER_PHASE);
		end

		// let everything owed arrive, then watch for strays
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mirror.errors == 0 && mirror.pending() == 0)
			$display("** text_console_put_char: PASSED **");
		else
			$display("** text_console_put_char: FAILED **");
		$finish;
	end

endmodule
